FILE: design/imu_sample_calibrator_assert.svh
// Assertion macros used by the calibrator back end.
`ifndef IMU_SAMPLE_CALIBRATOR_ASSERT_SVH
`define IMU_SAMPLE_CALIBRATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define IMUCAL_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("imucal check failed");
// Clocked check that also holds during reset.
`define IMUCAL_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("imucal check failed");
`else
`define IMUCAL_ASSERT(lbl, clk_s, rst_s, prop)
`define IMUCAL_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

FILE: design/imucal_pkg.sv
// Shared types and constants of the motion-sensor sample calibrator.
package imucal_pkg;

  localparam int AXIS_N     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COARSE_W   = 32;
  localparam int FINE_W     = 16;
  localparam int DATA_W     = 192;
  localparam int CAL_N      = 6;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 8;
  localparam int SUM_W      = 24;
  localparam int DIFF_W     = 21;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = 37;
  localparam int FRAC_W     = 18;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam int unsigned BIAS_SAMPLES_DEF = 100;
  localparam logic [CFG_DATA_W-1:0] CAL_RESET = 32'h0000_4000;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_STREAM_ENABLE,
    REG_ACCEL_CAL_X,
    REG_ACCEL_CAL_Y,
    REG_ACCEL_CAL_Z,
    REG_MAG_CAL_X,
    REG_MAG_CAL_Y,
    REG_MAG_CAL_Z
  } reg_idx_t;

  // What the back end does with a queued sample.
  typedef enum logic [1:0] {
    KIND_LEARN,
    KIND_LEARN_LAST,
    KIND_FRAME
  } kind_t;

  typedef struct packed {
    logic [COARSE_W-1:0]            time_coarse;
    logic [FINE_W-1:0]              time_fine;
    logic [AXIS_N-1:0][SAMPLE_W-1:0] accel;
    logic [AXIS_N-1:0][SAMPLE_W-1:0] gyro;
    logic [AXIS_N-1:0][SAMPLE_W-1:0] mag;
  } sample_t;

  typedef struct packed {
    kind_t   kind;
    sample_t smp;
  } entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  // Status of the bias divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/imu_sample_calibrator.sv
// Top level of the motion-sensor sample calibrator with its register file.
//
// Input channel in_*: one 192-bit sample word per handshake (timestamp, accel,
// gyro and mag axes). Output channel out_*: one calibrated frame word with the
// same layout. Configuration goes through the APB-style cfg_* port; the user
// must write it only while the block is idle, which the block does not enforce;
// pready is always high. While stream_enable is 0 every input word is taken
// and dropped. The first BIAS_SAMPLES enabled words only build the gyro sums
// and give no output; after the last of them a reciprocal-multiply divider
// forms the three means, and while it is busy the back end takes nothing from
// the queue (up to four words are queued before in_tready drops).
// Afterwards the block takes one word per cycle while out_tready stays high.
// A word enters the queue at its accepting edge, then passes the multiply stage
// and the saturate stage before its frame reaches out_tdata. The multiplies,
// 21x17 per calibrated axis and 24x25 per bias mean, set the cycle time.
// When out_tready is low the output register holds its word, the stages fill
// and then the queue; in_tready falls only once the queue is full.
// Reset clears the registers to offset 0 and gain 1.0, disables streaming
// and restarts bias learning.
module imu_sample_calibrator #(
  parameter int unsigned BIAS_SAMPLES = imucal_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: time_coarse, time_fine, accel_x/y/z_raw, gyro_x/y/z_raw, mag_x/y/z_raw
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [imucal_pkg::DATA_W-1:0]     in_tdata,
  // out_tdata: stamp_coarse, stamp_fine, accel_x/y/z_cal, gyro_x/y/z_cal, mag_x/y/z_cal
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [imucal_pkg::DATA_W-1:0]     out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [imucal_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [imucal_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [imucal_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  logic                                                  enable_r;
  logic [imucal_pkg::CAL_N-1:0][imucal_pkg::CFG_DATA_W-1:0] cal_r;
  logic                                                  cfg_wr;
  imucal_pkg::reg_idx_t                                  reg_idx;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  imucal_pkg::entry_t q_entry;
  imucal_pkg::qhead_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = imucal_pkg::reg_idx_t'(cfg_paddr[imucal_pkg::CFG_ADDR_W-1:2]);

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int i = 0; i < imucal_pkg::CAL_N; i++) begin
        cal_r[i] <= imucal_pkg::CAL_RESET;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        imucal_pkg::REG_STREAM_ENABLE: enable_r <= cfg_pwdata[0];
        imucal_pkg::REG_ACCEL_CAL_X:   cal_r[0] <= cfg_pwdata;
        imucal_pkg::REG_ACCEL_CAL_Y:   cal_r[1] <= cfg_pwdata;
        imucal_pkg::REG_ACCEL_CAL_Z:   cal_r[2] <= cfg_pwdata;
        imucal_pkg::REG_MAG_CAL_X:     cal_r[3] <= cfg_pwdata;
        imucal_pkg::REG_MAG_CAL_Y:     cal_r[4] <= cfg_pwdata;
        imucal_pkg::REG_MAG_CAL_Z:     cal_r[5] <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      imucal_pkg::REG_STREAM_ENABLE:
        cfg_prdata = {{(imucal_pkg::CFG_DATA_W-1){1'b0}}, enable_r};
      imucal_pkg::REG_ACCEL_CAL_X: cfg_prdata = cal_r[0];
      imucal_pkg::REG_ACCEL_CAL_Y: cfg_prdata = cal_r[1];
      imucal_pkg::REG_ACCEL_CAL_Z: cfg_prdata = cal_r[2];
      imucal_pkg::REG_MAG_CAL_X:   cfg_prdata = cal_r[3];
      imucal_pkg::REG_MAG_CAL_Y:   cfg_prdata = cal_r[4];
      imucal_pkg::REG_MAG_CAL_Z:   cfg_prdata = cal_r[5];
      default:                     cfg_prdata = '0;
    endcase
  end

  imucal_front #(
    .BIAS_SAMPLES (BIAS_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .stream_enable (enable_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  imucal_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  imucal_back #(
    .BIAS_SAMPLES (BIAS_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal_r),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: design/imucal_front.sv
// Front end: accepts input words, drops them while disabled and tags learning or frame.
module imucal_front #(
  parameter int unsigned BIAS_SAMPLES = imucal_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        stream_enable,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [imucal_pkg::DATA_W-1:0] in_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output imucal_pkg::entry_t          q_entry
);

  localparam logic [imucal_pkg::COUNT_W-1:0] NUM_V  =
    imucal_pkg::COUNT_W'(BIAS_SAMPLES);
  localparam logic [imucal_pkg::COUNT_W-1:0] LAST_V =
    imucal_pkg::COUNT_W'(BIAS_SAMPLES - 1);

  logic [imucal_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                           accept;
  logic                           learning;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign learning  = (count_r < NUM_V);
  assign q_push    = accept && stream_enable;

  // Unpack the word, first field in the lowest bits.
  always_comb begin
    q_entry.smp.time_coarse = in_tdata[31:0];
    q_entry.smp.time_fine   = in_tdata[47:32];
    for (int i = 0; i < imucal_pkg::AXIS_N; i++) begin
      q_entry.smp.accel[i] = in_tdata[48 + 16*i +: 16];
      q_entry.smp.gyro[i]  = in_tdata[96 + 16*i +: 16];
      q_entry.smp.mag[i]   = in_tdata[144 + 16*i +: 16];
    end
    if (!learning) begin
      q_entry.kind = imucal_pkg::KIND_FRAME;
    end else if (count_r == LAST_V) begin
      q_entry.kind = imucal_pkg::KIND_LEARN_LAST;
    end else begin
      q_entry.kind = imucal_pkg::KIND_LEARN;
    end
  end

  // Learning counter stops at the number of bias samples.
  always_comb begin
    count_nxt = count_r;
    if (q_push && learning) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: design/imucal_queue.sv
// Short queue between the front and back ends.
module imucal_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  imucal_pkg::entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output imucal_pkg::qhead_t head
);

  imucal_pkg::entry_t                entries_r [imucal_pkg::QDEPTH];
  logic [imucal_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [imucal_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [imucal_pkg::QCNT_W-1:0]     fill_r, fill_nxt;

  assign full        = (fill_r == imucal_pkg::QCNT_W'(imucal_pkg::QDEPTH));
  assign head.valid  = (fill_r != '0);
  assign head.entry  = entries_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: design/imucal_bias_div.sv
// Bias divider: divides the three gyro sums by a constant with a reciprocal multiply.
module imucal_bias_div #(
  parameter int unsigned DIVISOR = imucal_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             start,
  input  logic [imucal_pkg::AXIS_N-1:0][imucal_pkg::SUM_W-1:0] sum_in,
  output imucal_pkg::div_stat_t                            stat,
  output logic [imucal_pkg::AXIS_N-1:0][imucal_pkg::SUM_W-1:0] mean
);

  localparam int AX      = imucal_pkg::AXIS_N;
  localparam int SW      = imucal_pkg::SUM_W;
  // The magnitude is below 2^SW, so ceil(2^(SW + log2 d) / d) gives an exact
  // floor division and fits in SW + 1 bits.
  localparam int SHIFT_V = SW + $clog2(DIVISOR);
  localparam int RECIP_W = SW + 1;
  localparam int MUL_W   = SHIFT_V + SW;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SHIFT_V) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_L[RECIP_W-1:0];

  logic                      busy_r;
  logic                      done_r;
  logic [AX-1:0]             neg_r;
  logic [AX-1:0][SW-1:0]     mag_r;
  logic [AX-1:0][SW-1:0]     quo_r;
  logic [AX-1:0][MUL_W-1:0]  prod;

  assign stat.busy = busy_r || done_r;
  assign stat.done = done_r;

  // Magnitude times reciprocal, then the sign goes back on the quotient.
  always_comb begin
    for (int i = 0; i < AX; i++) begin
      prod[i] = mag_r[i] * RECIP_V;
      mean[i] = neg_r[i] ? -quo_r[i] : quo_r[i];
    end
  end

  // Start loads the magnitudes, the next cycle forms the quotients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < AX; i++) begin
        neg_r[i] <= sum_in[i][SW-1];
        mag_r[i] <= sum_in[i][SW-1] ? -sum_in[i] : sum_in[i];
      end
    end
    if (busy_r) begin
      for (int i = 0; i < AX; i++) begin
        quo_r[i] <= prod[i][SHIFT_V +: SW];
      end
    end
  end

endmodule

FILE: design/imucal_back.sv
// Back end: gyro bias learning and the two-stage calibration pipeline.
`include "imu_sample_calibrator_assert.svh"

module imucal_back #(
  parameter int unsigned BIAS_SAMPLES = imucal_pkg::BIAS_SAMPLES_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic [imucal_pkg::CAL_N-1:0][imucal_pkg::CFG_DATA_W-1:0] cal,
  input  imucal_pkg::qhead_t                                    head,
  output logic                                                  pop,
  output logic                                                  out_tvalid,
  input  logic                                                  out_tready,
  output logic [imucal_pkg::DATA_W-1:0]                         out_tdata
);

  localparam int AX = imucal_pkg::AXIS_N;
  localparam int SW = imucal_pkg::SAMPLE_W;
  localparam logic signed [imucal_pkg::PROD_W-1:0] ROUND_V =
    imucal_pkg::PROD_W'((1 << imucal_pkg::FRAC_W) - 1);
  localparam logic signed [imucal_pkg::PROD_W-1:0] MAX_V = imucal_pkg::PROD_W'(32767);
  localparam logic signed [imucal_pkg::PROD_W-1:0] MIN_V = -imucal_pkg::PROD_W'(32768);

  // Gyro sums while learning, means afterwards.
  logic [AX-1:0][imucal_pkg::SUM_W-1:0] bias_r;
  logic [AX-1:0][imucal_pkg::SUM_W-1:0] sum_nxt;
  logic [AX-1:0][imucal_pkg::SUM_W-1:0] mean;
  imucal_pkg::div_stat_t                div_stat;
  logic                                 div_start;

  logic o_ready, p_ready;
  logic pop_frame, pop_learn;

  // Product stage.
  logic                                      p_valid_r;
  logic [imucal_pkg::COARSE_W-1:0]           p_coarse_r;
  logic [imucal_pkg::FINE_W-1:0]             p_fine_r;
  logic [AX-1:0][SW-1:0]                     p_gyro_r;
  logic [imucal_pkg::CAL_N-1:0][imucal_pkg::PROD_W-1:0] p_prod_r;
  logic [AX-1:0][SW-1:0]                     gyro_cal;
  logic [imucal_pkg::CAL_N-1:0][imucal_pkg::PROD_W-1:0] prod;

  // Output stage.
  logic                                      out_valid_r;
  logic [imucal_pkg::DATA_W-1:0]             out_data_r;
  logic [imucal_pkg::CAL_N-1:0][SW-1:0]      sat;

  assign o_ready   = !out_valid_r || out_tready;
  assign p_ready   = !p_valid_r || o_ready;
  assign pop       = head.valid && !div_stat.busy &&
                     ((head.entry.kind != imucal_pkg::KIND_FRAME) || p_ready);
  assign pop_frame = pop && (head.entry.kind == imucal_pkg::KIND_FRAME);
  assign pop_learn = pop && (head.entry.kind != imucal_pkg::KIND_FRAME);
  assign div_start = pop && (head.entry.kind == imucal_pkg::KIND_LEARN_LAST);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Running gyro sums.
  always_comb begin
    for (int i = 0; i < AX; i++) begin
      sum_nxt[i] = bias_r[i] +
                   {{(imucal_pkg::SUM_W-SW){head.entry.smp.gyro[i][SW-1]}},
                    head.entry.smp.gyro[i]};
    end
  end

  imucal_bias_div #(
    .DIVISOR (BIAS_SAMPLES)
  ) u_bias_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .sum_in (sum_nxt),
    .stat   (div_stat),
    .mean   (mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (pop_learn) begin
      bias_r <= sum_nxt;
    end else if (div_stat.done) begin
      bias_r <= mean;
    end
  end

  // Offset removal and gain multiply for accel (0..2) and mag (3..5), and gyro bias removal.
  always_comb begin
    logic signed [imucal_pkg::DIFF_W-1:0] d;
    logic signed [SW-1:0]                 raw;
    logic signed [SW-1:0]                 offs;
    logic signed [imucal_pkg::GAIN_W:0]   gain;
    for (int i = 0; i < imucal_pkg::CAL_N; i++) begin
      raw  = (i < AX) ? $signed(head.entry.smp.accel[i % AX])
                      : $signed(head.entry.smp.mag[i % AX]);
      offs = $signed(cal[i][imucal_pkg::CFG_DATA_W-1:imucal_pkg::GAIN_W]);
      gain = $signed({1'b0, cal[i][imucal_pkg::GAIN_W-1:0]});
      d    = (imucal_pkg::DIFF_W'(raw) <<< 4) - imucal_pkg::DIFF_W'(offs);
      prod[i] = d * gain;
    end
    for (int i = 0; i < AX; i++) begin
      gyro_cal[i] = head.entry.smp.gyro[i] - bias_r[i][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= pop_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && pop_frame) begin
      p_coarse_r <= head.entry.smp.time_coarse;
      p_fine_r   <= head.entry.smp.time_fine;
      p_gyro_r   <= gyro_cal;
      p_prod_r   <= prod;
    end
  end

  // Truncate toward zero by 2^18 and clamp to 16 bits.
  always_comb begin
    logic signed [imucal_pkg::PROD_W-1:0] p;
    logic signed [imucal_pkg::PROD_W-1:0] q;
    for (int i = 0; i < imucal_pkg::CAL_N; i++) begin
      p = $signed(p_prod_r[i]);
      q = (p[imucal_pkg::PROD_W-1] ? (p + ROUND_V) : p) >>> imucal_pkg::FRAC_W;
      if (q > MAX_V) begin
        sat[i] = 16'h7fff;
      end else if (q < MIN_V) begin
        sat[i] = 16'h8000;
      end else begin
        sat[i] = q[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= p_valid_r;
    end
  end

  // Pack the result word, first field in the lowest bits.
  always_ff @(posedge clk) begin
    if (o_ready && p_valid_r) begin
      out_data_r[31:0]  <= p_coarse_r;
      out_data_r[47:32] <= p_fine_r;
      for (int i = 0; i < AX; i++) begin
        out_data_r[48 + 16*i +: 16]  <= sat[i];
        out_data_r[96 + 16*i +: 16]  <= p_gyro_r[i];
        out_data_r[144 + 16*i +: 16] <= sat[AX + i];
      end
    end
  end

  // Nothing leaves the queue while the bias is being divided.
  `IMUCAL_ASSERT(a_no_pop_while_div, clk, rst_n, div_stat.busy |-> !pop)
  // Starting the divider marks it busy on the next cycle.
  `IMUCAL_ASSERT(a_div_start_busy, clk, rst_n, div_start |=> div_stat.busy)
  // The bias only moves on a learning word or when the divider finishes.
  `IMUCAL_ASSERT(a_bias_stable, clk, rst_n,
    (!pop_learn && !div_stat.done) |=> $stable(bias_r))

endmodule

FILE: sim/imu_sample_calibrator_test.sv
// Self-checking testbench for the motion-sensor sample calibrator.
`timescale 1ns / 100ps

module imu_sample_calibrator_test;

  localparam int unsigned BIAS_N = imucal_pkg::BIAS_SAMPLES_DEF;
  localparam int REG_UNMAPPED = 7;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 190;

  // Tracks the calibration state and holds the frames still to come out.
  class calib_scoreboard;
    bit stream_on;
    logic [imucal_pkg::CFG_DATA_W-1:0] cal_word [imucal_pkg::CAL_N];
    int unsigned learn_count;
    int gyro_acc [imucal_pkg::AXIS_N];
    logic [imucal_pkg::DATA_W-1:0] pending_frames [$];
    int unsigned fail_count;

    function new();
      stream_on = 1'b0;
      foreach (cal_word[i]) cal_word[i] = imucal_pkg::CAL_RESET;
      learn_count = 0;
      foreach (gyro_acc[i]) gyro_acc[i] = 0;
      fail_count = 0;
    endfunction

    function void note_register(int idx, logic [31:0] value);
      if (idx == int'(imucal_pkg::REG_STREAM_ENABLE)) begin
        stream_on = value[0];
      end else if (idx >= int'(imucal_pkg::REG_ACCEL_CAL_X) &&
                   idx <= int'(imucal_pkg::REG_MAG_CAL_Z)) begin
        cal_word[idx - int'(imucal_pkg::REG_ACCEL_CAL_X)] = value;
      end
    endfunction

    // (16 * raw - offset) * gain in Q.18, truncated toward zero and clamped to 16 bits.
    function logic [15:0] calibrate_axis(logic signed [15:0] raw, logic [31:0] cal);
      longint offset;
      longint gain;
      longint q;
      offset = longint'($signed(cal[31:16]));
      gain = longint'(cal[15:0]);
      q = ((longint'(raw) * 16 - offset) * gain) / 262144;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_sample(logic [imucal_pkg::DATA_W-1:0] w);
      logic signed [15:0] ax [9];
      logic [imucal_pkg::DATA_W-1:0] f;
      if (!stream_on) return;
      for (int i = 0; i < 9; i++) ax[i] = w[48 + 16 * i +: 16];
      // Bias learning: sum the gyro axes, and turn the sums into means on the last word.
      if (learn_count < BIAS_N) begin
        learn_count++;
        for (int g = 0; g < imucal_pkg::AXIS_N; g++) gyro_acc[g] += int'(ax[3 + g]);
        if (learn_count == BIAS_N) begin
          for (int g = 0; g < imucal_pkg::AXIS_N; g++) begin
            gyro_acc[g] = gyro_acc[g] / int'(BIAS_N);
          end
        end
        return;
      end
      f = '0;
      f[47:0] = w[47:0];
      for (int i = 0; i < imucal_pkg::AXIS_N; i++) begin
        f[48 + 16 * i +: 16] = calibrate_axis(ax[i], cal_word[i]);
        f[96 + 16 * i +: 16] = ax[3 + i] - gyro_acc[i][15:0];
        f[144 + 16 * i +: 16] = calibrate_axis(ax[6 + i], cal_word[3 + i]);
      end
      pending_frames.push_back(f);
    endfunction

    function string field_name(int f);
      case (f)
        0: return "stamp_coarse";
        1: return "stamp_fine";
        2: return "accel_x_cal";
        3: return "accel_y_cal";
        4: return "accel_z_cal";
        5: return "gyro_x_cal";
        6: return "gyro_y_cal";
        7: return "gyro_z_cal";
        8: return "mag_x_cal";
        9: return "mag_y_cal";
        default: return "mag_z_cal";
      endcase
    endfunction

    function void check_frame(logic [imucal_pkg::DATA_W-1:0] got);
      logic [imucal_pkg::DATA_W-1:0] want;
      logic [31:0] mask;
      logic [31:0] want_f;
      logic [31:0] got_f;
      int lsb;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: out_tdata %h", got);
        fail_count++;
        return;
      end
      want = pending_frames.pop_front();
      for (int f = 0; f < 11; f++) begin
        lsb = (f == 0) ? 0 : 16 + 16 * f;
        mask = (f == 0) ? 32'hffff_ffff : 32'h0000_ffff;
        want_f = 32'(want >> lsb) & mask;
        got_f = 32'(got >> lsb) & mask;
        if (want_f !== got_f) begin
          $error("%s: expected %h, actual %h", field_name(f), want_f, got_f);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // in_tdata: time_coarse, time_fine, accel_x/y/z_raw, gyro_x/y/z_raw, mag_x/y/z_raw
  logic [imucal_pkg::DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata: stamp_coarse, stamp_fine, accel_x/y/z_cal, gyro_x/y/z_cal, mag_x/y/z_cal
  logic [imucal_pkg::DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [imucal_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [imucal_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [imucal_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  calib_scoreboard sb;
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int ready_left = 0;

  imu_sample_calibrator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_sample_calibrator regression: fail");
      $finish;
    end
  end

  // Result side: check each accepted word and stall in random bursts unless no_idle is set.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      ready_left = $urandom_range(1, 7) - 1;
    end else begin
      out_tready <= 1'b1;
      ready_left = $urandom_range(1, 24) - 1;
    end
  end

  // Register write: setup cycle, access cycle until pready, then the bus goes idle.
  task automatic cfg_write(int idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= imucal_pkg::CFG_ADDR_W'(idx * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    sb.note_register(idx, value);
  endtask

  // Offers one word, with an occasional gap ahead of it, and waits for its handshake.
  task automatic send_word(logic [imucal_pkg::DATA_W-1:0] w);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(w);
  endtask

  // Stops sending and waits for all pending frames; the tail covers the bias divider.
  task automatic drain_frames(bit with_tail);
    if (!with_tail && sb.pending_frames.size() == 0) return;
    in_tvalid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    if (with_tail) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($urandom_range(0, 4095) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_cal();
    logic [15:0] off;
    logic [15:0] gain;
    case ($urandom_range(0, 5))
      0: off = 16'h8000;
      1: off = 16'h7fff;
      2, 3: off = 16'($urandom_range(0, 511) - 256);
      default: off = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: gain = 16'h0000;
      1: gain = 16'hffff;
      2: gain = 16'h4000;
      3: gain = 16'($urandom_range(16'h3000, 16'h5000));
      default: gain = 16'($urandom);
    endcase
    return {off, gain};
  endfunction

  // Random sample; during learning the gyro x bias is pushed high and y low,
  // so that later extremes wrap.
  function automatic logic [imucal_pkg::DATA_W-1:0] make_word(bit learning);
    logic [imucal_pkg::DATA_W-1:0] w;
    w[31:0] = $urandom;
    w[47:32] = 16'($urandom);
    for (int i = 0; i < 9; i++) w[48 + 16 * i +: 16] = pick_axis();
    if (learning) begin
      w[96 +: 16] = 16'($urandom_range(15000, 32767));
      w[112 +: 16] = 16'h0000 - 16'($urandom_range(15000, 32768));
    end
    return w;
  endfunction

  function automatic logic [imucal_pkg::DATA_W-1:0] uniform_word(logic [31:0] stamp,
                                                                 logic [15:0] v);
    logic [imucal_pkg::DATA_W-1:0] w;
    w[31:0] = stamp;
    w[47:32] = ~stamp[15:0];
    for (int i = 0; i < 9; i++) w[48 + 16 * i +: 16] = v;
    return w;
  endfunction

  // Main sequence.
  initial begin
    logic [15:0] edge_vals [8];
    int n_words;
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'hfff0, 16'h0100,
                  16'h1000};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Streaming is off after reset, so these words are dropped.
    repeat (3) send_word(make_word(1'b0));
    drain_frames(1'b1);
    // Upper bits of the enable register are ignored; a write to an unmapped index too.
    cfg_write(imucal_pkg::REG_STREAM_ENABLE, 32'hffff_fffe);
    cfg_write(REG_UNMAPPED, $urandom);
    repeat (2) send_word(make_word(1'b0));
    drain_frames(1'b1);

    // Extreme offsets and gains, then bias learning straight into frames.
    cfg_write(imucal_pkg::REG_ACCEL_CAL_X, 32'h8000_ffff);
    cfg_write(imucal_pkg::REG_ACCEL_CAL_Y, 32'h7fff_0000);
    cfg_write(imucal_pkg::REG_ACCEL_CAL_Z, 32'h0000_4000);
    cfg_write(imucal_pkg::REG_MAG_CAL_X, 32'h0001_ffff);
    cfg_write(imucal_pkg::REG_MAG_CAL_Y, 32'hffff_8000);
    cfg_write(imucal_pkg::REG_MAG_CAL_Z, 32'h8000_0001);
    cfg_write(imucal_pkg::REG_STREAM_ENABLE, 32'h0000_0003);
    repeat (BIAS_N) send_word(make_word(1'b1));
    for (int i = 0; i < 8; i++) begin
      send_word(uniform_word((i % 2 == 0) ? 32'h0 : 32'hffff_ffff, edge_vals[i]));
    end
    drain_frames(1'b1);
    cfg_write(imucal_pkg::REG_ACCEL_CAL_X, 32'h7fff_ffff);
    cfg_write(imucal_pkg::REG_ACCEL_CAL_Y, 32'h8000_ffff);
    cfg_write(imucal_pkg::REG_ACCEL_CAL_Z, 32'h0000_ffff);
    cfg_write(imucal_pkg::REG_MAG_CAL_X, 32'h8000_4000);
    cfg_write(imucal_pkg::REG_MAG_CAL_Y, 32'h7fff_4000);
    cfg_write(imucal_pkg::REG_MAG_CAL_Z, 32'hfff0_2000);
    for (int i = 0; i < 8; i++) begin
      send_word(uniform_word($urandom, edge_vals[7 - i]));
    end

    // Random phases, each under a fresh calibration.
    for (int phase = 0; phase < 8; phase++) begin
      drain_frames(1'b1);
      if (phase == 3) begin
        cfg_write(imucal_pkg::REG_STREAM_ENABLE,
                  {$urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0, 1'b0});
        repeat (15) send_word(make_word(1'b0));
        drain_frames(1'b1);
      end
      for (int r = int'(imucal_pkg::REG_ACCEL_CAL_X); r <= int'(imucal_pkg::REG_MAG_CAL_Z);
           r++) begin
        cfg_write(r, rand_cal());
      end
      cfg_write(imucal_pkg::REG_STREAM_ENABLE, {31'($urandom), 1'b1});
      if (phase == 7) no_idle = 1'b1;
      n_words = PHASE_WORDS;
      for (int k = 0; k < n_words; k++) begin
        // Hold off now and then until every pending frame is out.
        if (k == n_words / 2 && (phase == 0 || $urandom_range(0, 1) == 1)) drain_frames(1'b0);
        send_word(make_word(1'b0));
      end
    end

    drain_frames(1'b1);
    if (sb.fail_count == 0) begin
      $display("imu_sample_calibrator regression: pass");
    end else begin
      $display("imu_sample_calibrator regression: fail");
    end
    $finish;
  end

endmodule
